>>> design/poincare_disk_distance_macros.svh
// Assertion macros for the Poincare disk distance block.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef POINCARE_DISK_DISTANCE_MACROS_SVH
`define POINCARE_DISK_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("poincare_disk_distance: same-cycle check failed");
// next-cycle implication
`define PDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("poincare_disk_distance: next-cycle check failed");
`else
`define PDD_ASSERT_NOW(label, ante, cons)
`define PDD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/pdd_pkg.sv
// Shared constants and types of the Poincare disk distance block.
// No dependencies; used by every other file of the block but the macros header.
`timescale 1ns / 1ps
`default_nettype none

package pdd_pkg;

  // field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // radius after reset: 1.0 in Q16.16
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // unit disk coordinates are Q2.30
  localparam int unsigned UNIT_FRAC = 30;

  // log2 fraction bits, ln2 constant and distance fraction bits
  localparam int unsigned LOG_FRAC  = 28;
  localparam int unsigned LN2_FRAC  = 30;
  localparam logic [LN2_FRAC-1:0] LN2_Q30 = 30'd744261118;
  localparam int unsigned DIST_FRAC = 24;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_DENOM   = 2'd2
  } status_t;

  // classified request from the front
  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic                      outside;
  } pdd_item_t;

  // Mobius norm handed to the log stage
  typedef struct packed {
    logic                 valid;
    logic [UNIT_FRAC-1:0] root;
    status_t              status;
  } pdd_root_t;

endpackage

`default_nettype wire

>>> design/pdd_if.sv
// Valid/ready channel interfaces for the point-pair input and distance output.
// Depends on pdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pdd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pdd_pkg::COORD_W-1:0] first_x;
  logic signed [pdd_pkg::COORD_W-1:0] first_y;
  logic signed [pdd_pkg::COORD_W-1:0] second_x;
  logic signed [pdd_pkg::COORD_W-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface pdd_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdd_pkg::DIST_W-1:0]    distance;
  logic [pdd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

`default_nettype wire

>>> design/pdd_front.sv
// Front end: accepts point pairs, squares them and flags points outside the disk.
// Depends on pdd_pkg and pdd_if.
`timescale 1ns / 1ps
`default_nettype none

module pdd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [2*pdd_pkg::RADIUS_W-1:0]    radius_sq,
  pdd_in_if.sink                            in_chan,
  output logic                              push_valid,
  output pdd_pkg::pdd_item_t                push_item,
  input  logic                              push_ready
);

  localparam int unsigned CW = pdd_pkg::COORD_W;
  localparam int unsigned SW = 2 * CW;

  logic                 adv;
  logic                 f1_valid_r;
  pdd_pkg::pdd_item_t   f1_item_r;
  logic [SW-1:0]        f1_sq_r [4];
  logic                 f2_valid_r;
  pdd_pkg::pdd_item_t   f2_item_r;

  logic signed [CW-1:0] coord [4];
  logic [CW-1:0]        mag [4];
  logic [SW-1:0]        sum_first;
  logic [SW-1:0]        sum_second;

  // both stages move together whenever the last one can drain
  assign adv           = !f2_valid_r || push_ready;
  assign in_chan.ready = adv;
  assign push_valid    = f2_valid_r;
  assign push_item     = f2_item_r;

  // coordinate magnitudes
  always_comb begin
    coord[0] = in_chan.first_x;
    coord[1] = in_chan.first_y;
    coord[2] = in_chan.second_x;
    coord[3] = in_chan.second_y;
    for (int l = 0; l < 4; l++) begin
      mag[l] = coord[l][CW-1] ? CW'(-coord[l]) : CW'(coord[l]);
    end
  end

  // squared radius test, exact on raw Q16.16
  always_comb begin
    sum_first  = f1_sq_r[0] + f1_sq_r[1];
    sum_second = f1_sq_r[2] + f1_sq_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_chan.valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_item_r.first_x  <= in_chan.first_x;
      f1_item_r.first_y  <= in_chan.first_y;
      f1_item_r.second_x <= in_chan.second_x;
      f1_item_r.second_y <= in_chan.second_y;
      f1_item_r.outside  <= 1'b0;
      for (int l = 0; l < 4; l++) begin
        f1_sq_r[l] <= SW'(mag[l]) * SW'(mag[l]);
      end
      f2_item_r.first_x  <= f1_item_r.first_x;
      f2_item_r.first_y  <= f1_item_r.first_y;
      f2_item_r.second_x <= f1_item_r.second_x;
      f2_item_r.second_y <= f1_item_r.second_y;
      f2_item_r.outside  <= !(sum_first < SW'(radius_sq)) || !(sum_second < SW'(radius_sq));
    end
  end

endmodule

`default_nettype wire

>>> design/pdd_fifo.sv
// Request queue between the front end and the arithmetic back end.
// Depends on pdd_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module pdd_fifo #(
  parameter int unsigned DEPTH = pdd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  pdd_pkg::pdd_item_t push_item,
  output logic               push_ready,
  input  logic               pop,
  output logic               head_valid,
  output pdd_pkg::pdd_item_t head_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  pdd_pkg::pdd_item_t entry_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [NW-1:0]      count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> design/pdd_back.sv
// Back end: scales points to the unit disk, forms the Mobius norm squared by
// restoring division and takes its integer square root. Depends on pdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [pdd_pkg::RADIUS_W-1:0]   radius,
  input  logic                           head_valid,
  input  pdd_pkg::pdd_item_t             head_item,
  output pdd_pkg::pdd_root_t             root
);

  localparam int unsigned UF = pdd_pkg::UNIT_FRAC;
  localparam int unsigned QW = 2 * UF;
  localparam int unsigned CW = pdd_pkg::COORD_W;
  localparam int unsigned TW = CW + 1;
  localparam int unsigned WW = 128;
  localparam logic [QW:0] ONE_UNIT = {1'b1, {QW{1'b0}}};

  // ---------------- scaling: u = (|c| << UF) / r, one bit a stage
  logic                 sc_valid_r [0:UF];
  logic                 sc_out_r   [0:UF];
  logic [3:0]           sc_neg_r   [0:UF];
  logic [3:0][CW-1:0]   sc_rem_r   [0:UF];
  logic [3:0][UF-1:0]   sc_quo_r   [0:UF];

  logic signed [CW-1:0] coord [4];

  always_comb begin
    coord[0] = head_item.first_x;
    coord[1] = head_item.first_y;
    coord[2] = head_item.second_x;
    coord[3] = head_item.second_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r[0] <= 1'b0;
    end else if (adv) begin
      sc_valid_r[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_out_r[0] <= head_item.outside;
      for (int l = 0; l < 4; l++) begin
        sc_neg_r[0][l] <= coord[l][CW-1];
        sc_rem_r[0][l] <= coord[l][CW-1] ? CW'(-coord[l]) : CW'(coord[l]);
        sc_quo_r[0][l] <= '0;
      end
    end
  end

  for (genvar i = 0; i < UF; i++) begin : g_scale
    logic [3:0][CW-1:0] rem_nxt;
    logic [3:0][UF-1:0] quo_nxt;
    logic [TW-1:0]      trial [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {sc_rem_r[i][l], 1'b0};
        if (trial[l] >= TW'(radius)) begin
          rem_nxt[l] = CW'(trial[l] - TW'(radius));
          quo_nxt[l] = {sc_quo_r[i][l][UF-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][CW-1:0];
          quo_nxt[l] = {sc_quo_r[i][l][UF-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sc_valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        sc_valid_r[i+1] <= sc_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sc_out_r[i+1] <= sc_out_r[i];
        sc_neg_r[i+1] <= sc_neg_r[i];
        sc_rem_r[i+1] <= rem_nxt;
        sc_quo_r[i+1] <= quo_nxt;
      end
    end
  end

  // ---------------- Mobius terms
  logic                 m1_valid_r, m2_valid_r, m3_valid_r, m4_valid_r, m5_valid_r, m6_valid_r;
  logic                 m1_out_r, m2_out_r, m3_out_r, m4_out_r, m5_out_r, m6_out_r;
  logic [UF-1:0]        m1_um_r  [4];
  logic [UF:0]          m1_dm_r  [2];
  logic [QW-1:0]        m2_usq_r [4];
  logic [QW+1:0]        m2_dsq_r [2];
  logic [QW+2:0]        m3_num_r, m4_num_r, m5_num_r;
  logic [QW:0]          m3_e_r   [2];
  logic [2*UF+1:0]      m4_hh_r;
  logic [2*UF:0]        m4_hl_r, m4_lh_r;
  logic [2*UF-1:0]      m4_ll_r;
  logic [WW-1:0]        m5_prod_r;
  logic [WW-1:0]        m6_den_r, m6_rem_r;

  logic signed [CW-1:0] u [4];
  logic signed [CW-1:0] dlt [2];

  // signed unit coordinates and their differences
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      u[l] = sc_neg_r[UF][l] ? -$signed(CW'(sc_quo_r[UF][l])) : $signed(CW'(sc_quo_r[UF][l]));
    end
    dlt[0] = u[2] - u[0];
    dlt[1] = u[3] - u[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      m4_valid_r <= 1'b0;
      m5_valid_r <= 1'b0;
      m6_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r <= sc_valid_r[UF];
      m2_valid_r <= m1_valid_r;
      m3_valid_r <= m2_valid_r;
      m4_valid_r <= m3_valid_r;
      m5_valid_r <= m4_valid_r;
      m6_valid_r <= m5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // magnitudes
      m1_out_r <= sc_out_r[UF];
      for (int l = 0; l < 4; l++) begin
        m1_um_r[l] <= sc_quo_r[UF][l];
      end
      for (int k = 0; k < 2; k++) begin
        m1_dm_r[k] <= dlt[k][CW-1] ? (UF+1)'(-dlt[k]) : (UF+1)'(dlt[k]);
      end
      // squares in Q.60
      m2_out_r <= m1_out_r;
      for (int l = 0; l < 4; l++) begin
        m2_usq_r[l] <= QW'(m1_um_r[l]) * QW'(m1_um_r[l]);
      end
      for (int k = 0; k < 2; k++) begin
        m2_dsq_r[k] <= (QW+2)'(m1_dm_r[k]) * (QW+2)'(m1_dm_r[k]);
      end
      // |u2-u1|^2 and 1-|u|^2
      m3_out_r    <= m2_out_r;
      m3_num_r    <= (QW+3)'(m2_dsq_r[0]) + (QW+3)'(m2_dsq_r[1]);
      m3_e_r[0]   <= ONE_UNIT - (QW+1)'(m2_usq_r[0]) - (QW+1)'(m2_usq_r[1]);
      m3_e_r[1]   <= ONE_UNIT - (QW+1)'(m2_usq_r[2]) - (QW+1)'(m2_usq_r[3]);
      // partial products of (1-|u1|^2)(1-|u2|^2)
      m4_out_r <= m3_out_r;
      m4_num_r <= m3_num_r;
      m4_hh_r  <= (2*UF+2)'(m3_e_r[0][QW:UF]) * (2*UF+2)'(m3_e_r[1][QW:UF]);
      m4_hl_r  <= (2*UF+1)'(m3_e_r[0][QW:UF]) * (2*UF+1)'(m3_e_r[1][UF-1:0]);
      m4_lh_r  <= (2*UF+1)'(m3_e_r[0][UF-1:0]) * (2*UF+1)'(m3_e_r[1][QW:UF]);
      m4_ll_r  <= (2*UF)'(m3_e_r[0][UF-1:0]) * (2*UF)'(m3_e_r[1][UF-1:0]);
      // product in Q.120
      m5_out_r  <= m4_out_r;
      m5_num_r  <= m4_num_r;
      m5_prod_r <= (WW'(m4_hh_r) << QW) + ((WW'(m4_hl_r) + WW'(m4_lh_r)) << UF)
                   + WW'(m4_ll_r);
      // denominator D = num*2^60 + product
      m6_out_r <= m5_out_r;
      m6_rem_r <= WW'(m5_num_r) << QW;
      m6_den_r <= (WW'(m5_num_r) << QW) + m5_prod_r;
    end
  end

  // ---------------- restoring division n^2 = num*2^60 / D
  logic                 dv_valid_r [0:QW];
  pdd_pkg::status_t     dv_stat_r  [0:QW];
  logic                 dv_big_r   [0:QW];
  logic [WW-1:0]        dv_rem_r   [0:QW];
  logic [WW-1:0]        dv_den_r   [0:QW];
  logic [QW-1:0]        dv_quo_r   [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= m6_valid_r;
    end
  end

  // classify and load the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      if (m6_out_r) begin
        dv_stat_r[0] <= pdd_pkg::ST_OUTSIDE;
      end else if (m6_den_r == '0) begin
        dv_stat_r[0] <= pdd_pkg::ST_DENOM;
      end else begin
        dv_stat_r[0] <= pdd_pkg::ST_OK;
      end
      dv_big_r[0] <= (m6_rem_r >= m6_den_r);
      dv_rem_r[0] <= m6_rem_r;
      dv_den_r[0] <= m6_den_r;
      dv_quo_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [WW-1:0] shifted;
    logic [WW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    always_comb begin
      shifted = {dv_rem_r[i][WW-2:0], 1'b0};
      if (shifted >= dv_den_r[i]) begin
        rem_nxt = shifted - dv_den_r[i];
        quo_nxt = {dv_quo_r[i][QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {dv_quo_r[i][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[i+1] <= dv_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_stat_r[i+1] <= dv_stat_r[i];
        dv_big_r[i+1]  <= dv_big_r[i];
        dv_rem_r[i+1]  <= rem_nxt;
        dv_den_r[i+1]  <= dv_den_r[i];
        dv_quo_r[i+1]  <= quo_nxt;
      end
    end
  end

  // ---------------- integer square root, one result bit a stage
  logic                 sq_valid_r [0:UF];
  pdd_pkg::status_t     sq_stat_r  [0:UF];
  logic [QW-1:0]        sq_v_r     [0:UF];
  logic [QW-1:0]        sq_res_r   [0:UF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else if (adv) begin
      sq_valid_r[0] <= dv_valid_r[QW];
    end
  end

  // a quotient that would overflow saturates to one step below 1.0
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_stat_r[0] <= dv_stat_r[QW];
      sq_v_r[0]    <= dv_big_r[QW] ? {QW{1'b1}} : dv_quo_r[QW];
      sq_res_r[0]  <= '0;
    end
  end

  for (genvar i = 0; i < UF; i++) begin : g_sqrt
    localparam logic [QW-1:0] BIT = QW'(1) << (QW - 2 - 2 * i);
    logic [QW:0]   trial;
    logic [QW-1:0] v_nxt;
    logic [QW-1:0] res_nxt;

    always_comb begin
      trial = {1'b0, sq_res_r[i]} + {1'b0, BIT};
      if ({1'b0, sq_v_r[i]} >= trial) begin
        v_nxt   = sq_v_r[i] - trial[QW-1:0];
        res_nxt = (sq_res_r[i] >> 1) + BIT;
      end else begin
        v_nxt   = sq_v_r[i];
        res_nxt = sq_res_r[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        sq_valid_r[i+1] <= sq_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_stat_r[i+1] <= sq_stat_r[i];
        sq_v_r[i+1]    <= v_nxt;
        sq_res_r[i+1]  <= res_nxt;
      end
    end
  end

  // root of a value below 2^60 already fits below 2^30
  assign root.valid  = sq_valid_r[UF];
  assign root.root   = sq_res_r[UF][UF-1:0];
  assign root.status = sq_stat_r[UF];

endmodule

`default_nettype wire

>>> design/pdd_log.sv
// Distance stage: 2*atanh(n) as ln2 * (log2(1+n) - log2(1-n)) by repeated
// squaring, then the output register. Depends on pdd_pkg and pdd_if.
`timescale 1ns / 1ps
`default_nettype none

module pdd_log (
  input  logic               clk,
  input  logic               rst_n,
  input  pdd_pkg::pdd_root_t root,
  output logic               adv,
  pdd_out_if.source          out_chan
);

  localparam int unsigned UF    = pdd_pkg::UNIT_FRAC;
  localparam int unsigned LF    = pdd_pkg::LOG_FRAC;
  localparam int unsigned MW    = UF + 1;
  localparam int unsigned PW    = $clog2(UF + 1);
  localparam int unsigned DW    = PW + LF;
  localparam int unsigned KW    = pdd_pkg::LN2_FRAC;
  localparam int unsigned XW    = DW + KW;
  localparam int unsigned OW    = pdd_pkg::DIST_W;
  localparam int unsigned SHIFT = LF + KW - pdd_pkg::DIST_FRAC;
  localparam logic [MW-1:0] ONE_UNIT = {1'b1, {UF{1'b0}}};

  logic                 out_valid_r;
  logic [OW-1:0]        out_dist_r;
  pdd_pkg::status_t     out_stat_r;

  // the whole pipeline advances when the output slot is free or taken
  assign adv               = !out_valid_r || out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.distance = out_dist_r;
  assign out_chan.status   = out_stat_r;

  // ---------------- 1+n, 1-n and normalization of 1-n
  logic                 l0_valid_r, l1_valid_r;
  pdd_pkg::status_t     l0_stat_r, l1_stat_r;
  logic [MW-1:0]        l0_a_r, l0_b_r, l1_a_r, l1_b_r;
  logic [PW-1:0]        l1_p_r;
  logic [PW-1:0]        lead;

  // leading one of 1-n
  always_comb begin
    lead = '0;
    for (int j = 0; j < MW; j++) begin
      if (l0_b_r[j]) begin
        lead = PW'(j);
      end
    end
  end

  // ---------------- squaring stages
  logic                 lg_valid_r [0:LF];
  pdd_pkg::status_t     lg_stat_r  [0:LF];
  logic [PW-1:0]        lg_p_r     [0:LF];
  logic [MW-1:0]        lg_ma_r    [0:LF];
  logic [MW-1:0]        lg_mb_r    [0:LF];
  logic [LF-1:0]        lg_fa_r    [0:LF];
  logic [LF-1:0]        lg_fb_r    [0:LF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_valid_r    <= 1'b0;
      l1_valid_r    <= 1'b0;
      lg_valid_r[0] <= 1'b0;
    end else if (adv) begin
      l0_valid_r    <= root.valid;
      l1_valid_r    <= l0_valid_r;
      lg_valid_r[0] <= l1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l0_stat_r    <= root.status;
      l0_a_r       <= ONE_UNIT + MW'(root.root);
      l0_b_r       <= ONE_UNIT - MW'(root.root);
      l1_stat_r    <= l0_stat_r;
      l1_a_r       <= l0_a_r;
      l1_b_r       <= l0_b_r;
      l1_p_r       <= lead;
      // mantissas in Q1.30; 1+n always has its leading one at UF
      lg_stat_r[0] <= l1_stat_r;
      lg_p_r[0]    <= l1_p_r;
      lg_ma_r[0]   <= l1_a_r;
      lg_mb_r[0]   <= l1_b_r << (PW'(UF) - l1_p_r);
      lg_fa_r[0]   <= '0;
      lg_fb_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < LF; i++) begin : g_sq
    logic [2*MW-1:0] sqa, sqb;
    logic [MW:0]     ta, tb;
    logic [MW-1:0]   ma_nxt, mb_nxt;
    logic [LF-1:0]   fa_nxt, fb_nxt;

    always_comb begin
      sqa = (2*MW)'(lg_ma_r[i]) * (2*MW)'(lg_ma_r[i]);
      sqb = (2*MW)'(lg_mb_r[i]) * (2*MW)'(lg_mb_r[i]);
      ta  = sqa[2*MW-1:UF];
      tb  = sqb[2*MW-1:UF];
      // a square of 2.0 or more gives a one bit and halves the mantissa
      ma_nxt = ta[MW] ? ta[MW:1] : ta[MW-1:0];
      mb_nxt = tb[MW] ? tb[MW:1] : tb[MW-1:0];
      fa_nxt = {lg_fa_r[i][LF-2:0], ta[MW]};
      fb_nxt = {lg_fb_r[i][LF-2:0], tb[MW]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        lg_valid_r[i+1] <= lg_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lg_stat_r[i+1] <= lg_stat_r[i];
        lg_p_r[i+1]    <= lg_p_r[i];
        lg_ma_r[i+1]   <= ma_nxt;
        lg_mb_r[i+1]   <= mb_nxt;
        lg_fa_r[i+1]   <= fa_nxt;
        lg_fb_r[i+1]   <= fb_nxt;
      end
    end
  end

  // ---------------- difference, scale by ln2, round and saturate
  logic                 d1_valid_r, d2_valid_r;
  pdd_pkg::status_t     d1_stat_r, d2_stat_r;
  logic [DW-1:0]        d1_diff_r;
  logic [XW-1:0]        d2_prod_r;
  logic [XW:0]          rounded;
  logic [OW-1:0]        dist_sat;

  always_comb begin
    rounded  = ((XW+1)'(d2_prod_r) + ((XW+1)'(1) << (SHIFT - 1))) >> SHIFT;
    dist_sat = (rounded >> OW) != '0 ? {OW{1'b1}} : rounded[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r  <= 1'b0;
      d2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      d1_valid_r  <= lg_valid_r[LF];
      d2_valid_r  <= d1_valid_r;
      out_valid_r <= d2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_stat_r  <= lg_stat_r[LF];
      d1_diff_r  <= {PW'(UF), lg_fa_r[LF]} - {lg_p_r[LF], lg_fb_r[LF]};
      d2_stat_r  <= d1_stat_r;
      d2_prod_r  <= XW'(d1_diff_r) * XW'(pdd_pkg::LN2_Q30);
      out_stat_r <= d2_stat_r;
      // error results carry a zero distance
      out_dist_r <= (d2_stat_r == pdd_pkg::ST_OK) ? dist_sat : '0;
    end
  end

endmodule

`default_nettype wire

>>> design/poincare_disk_distance.sv
// Top level of the Poincare disk distance block: radius register, front end,
// request queue, back end and distance stage. Depends on pdd_pkg, pdd_if and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "poincare_disk_distance_macros.svh"

// Hyperbolic distance between two points of a 2-D Poincare disk. A request
// carries two Q16.16 points; the result gives 2*atanh of the Mobius norm in
// unsigned Q8.24 with a status (ok, point not inside disk, zero denominator).
// The block takes one request per clock while the request queue has room. Its
// pipeline depth comes from the 30-stage scaling divider, the 60-stage restoring
// divider for the squared norm, the 30-stage square root and 28 squaring
// stages of the log2 unit. A stalled output holds the whole back pipeline;
// the queue lets the front keep accepting meanwhile until the queue fills.
// disk_radius must be written through cfg_wr_en/cfg_wr_data only while idle;
// the block does not enforce it. Its square follows in the cycle after disk_radius_r updates.
module poincare_disk_distance #(
  parameter int unsigned QUEUE_DEPTH = pdd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pdd_pkg::RADIUS_W-1:0]  cfg_wr_data,
  pdd_in_if.sink                        in_chan,
  pdd_out_if.source                     out_chan
);

  localparam int unsigned RW = pdd_pkg::RADIUS_W;

  logic [RW-1:0]        disk_radius_r;
  logic [2*RW-1:0]      radius_sq_r;
  logic                 push_valid;
  logic                 push_ready;
  pdd_pkg::pdd_item_t   push_item;
  logic                 head_valid;
  pdd_pkg::pdd_item_t   head_item;
  logic                 adv;
  pdd_pkg::pdd_root_t   root;

  // radius register and its square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_radius_r <= pdd_pkg::RADIUS_RESET;
      radius_sq_r   <= (2*RW)'(pdd_pkg::RADIUS_RESET) * (2*RW)'(pdd_pkg::RADIUS_RESET);
    end else begin
      if (cfg_wr_en) begin
        disk_radius_r <= cfg_wr_data;
      end
      radius_sq_r <= (2*RW)'(disk_radius_r) * (2*RW)'(disk_radius_r);
    end
  end

  pdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius_sq  (radius_sq_r),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  pdd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (adv),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pdd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .radius     (disk_radius_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .root       (root)
  );

  pdd_log u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .root     (root),
    .adv      (adv),
    .out_chan (out_chan)
  );

  // checks
  `PDD_ASSERT_NOW(a_err_zero_dist, out_chan.valid && (out_chan.status != pdd_pkg::ST_OK), out_chan.distance == '0)
  `PDD_ASSERT_NEXT(a_stall_holds_root, !adv, $stable(root))
  `PDD_ASSERT_NEXT(a_front_holds_request, push_valid && !push_ready, push_valid)
  `PDD_ASSERT_NOW(a_radius_sq_match, !$past(cfg_wr_en), radius_sq_r == (2*RW)'(disk_radius_r) * (2*RW)'(disk_radius_r))

endmodule

`default_nettype wire
